FILE: rtl/tgfc_pkg.sv
package tgfc_pkg;

  localparam logic [6:0] CH_MASK    = 7'h7f;
  localparam logic [5:0] SUM_MASK   = 6'h3f;
  localparam logic [6:0] CKS_OFFSET = 7'h20;
  localparam logic [6:0] CH_LF      = 7'h0a;
  localparam logic [6:0] CH_CR      = 7'h0d;
  localparam logic [6:0] CH_STX     = 7'h02;

  localparam logic [7:0] MIN_LEN_RESET = 8'd8;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPW    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CKS   = 2'd1,
    ST_SHORT = 2'd2,
    ST_OVF   = 2'd3
  } status_e;

  typedef struct packed {
    logic       kind;
    status_e    status;
    logic [6:0] group_length;
    logic [6:0] computed_checksum;
    logic [6:0] received_checksum;
    logic       hit;
  } front_t;

  typedef struct packed {
    logic       kind;
    status_e    status;
    logic [6:0] group_length;
    logic [6:0] computed_checksum;
    logic [6:0] received_checksum;
    logic [6:0] read_data;
  } out_t;

endpackage

FILE: rtl/tic_group_framer_checksum.sv
// Channel   Dir  tuser  tdata (low bit up)
// s_axis    in   cmd    rx_byte[7:0], read_index[14:8], zero[15]
// m_axis    out  kind   status[1:0], group_length[8:2], computed_checksum[15:9],
//                       received_checksum[22:16], read_data[29:23], zero[31:30]
// cfg       in   -      min_group_len[7:0] on cfg_wdata_i when cfg_we_i is high
//
// One transaction is accepted per cycle while the result queue has room; a result is registered
// in the front stage, with the registered read of the group store, and then in the result queue.
// A four-entry result queue parts the two sides, and input is taken while it has room.
// Reset is asynchronous and clears all control state; the group store is not cleared.
module tic_group_framer_checksum #(
  parameter int unsigned BUF_SIZE = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic        s_axis_tuser_i,   // cmd
  input  logic [15:0] s_axis_tdata_i,   // rx_byte, read_index
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic        m_axis_tuser_o,   // kind
  output logic [31:0] m_axis_tdata_o    // status, group_length, checksums, read_data
);
  import tgfc_pkg::*;

  localparam int unsigned AW = $clog2(2 * BUF_SIZE);

  logic          accept;
  logic          room;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [6:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [6:0]    ram_rdata;
  logic          res_valid;
  front_t        res;
  out_t          out;

  assign s_axis_tready_o = room;
  assign accept          = s_axis_tvalid_i && room;

  tgfc_front #(
    .BUF_SIZE(BUF_SIZE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (accept),
    .cmd_i       (s_axis_tuser_i),
    .rx_byte_i   (s_axis_tdata_i[7:0]),
    .read_index_i(s_axis_tdata_i[14:8]),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tgfc_ram #(
    .WIDTH(7),
    .DEPTH(2 * BUF_SIZE)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  tgfc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_i      (res),
    .rdata_i    (ram_rdata),
    .room_o     (room),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_o      (out)
  );

  assign m_axis_tuser_o = out.kind;
  assign m_axis_tdata_o = {2'b00, out.read_data, out.received_checksum,
                           out.computed_checksum, out.group_length, out.status};

endmodule

FILE: rtl/tgfc_ram.sv
module tgfc_ram #(
  parameter int unsigned WIDTH = 7,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/tgfc_front.sv
module tgfc_front #(
  parameter int unsigned BUF_SIZE = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [7:0]                    cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          cmd_i,
  input  logic [7:0]                    rx_byte_i,
  input  logic [6:0]                    read_index_i,
  output logic                          ram_we_o,
  output logic [$clog2(2*BUF_SIZE)-1:0] ram_waddr_o,
  output logic [6:0]                    ram_wdata_o,
  output logic                          ram_re_o,
  output logic [$clog2(2*BUF_SIZE)-1:0] ram_raddr_o,
  output logic                          res_valid_o,
  output tgfc_pkg::front_t              res_o
);
  import tgfc_pkg::*;

  localparam int unsigned AW  = $clog2(2 * BUF_SIZE);
  localparam int unsigned WCW = $clog2(BUF_SIZE);
  localparam int unsigned CW  = (WCW > 7) ? WCW : 7;
  localparam int unsigned MW  = (WCW > 8) ? WCW : 8;

  logic [7:0]     min_len_q, min_len_d;
  logic           start_seen_q, start_seen_d;
  logic           in_group_q, in_group_d;
  logic [WCW-1:0] wc_q, wc_d;
  logic [5:0]     sum_q, sum_d;
  logic [6:0]     last_q, last_d;
  logic           bank_q, bank_d;
  logic [WCW-1:0] good_len_q, good_len_d;
  logic           res_valid_q, res_valid_d;
  front_t         res_q, res_d;

  logic [6:0]     c;
  logic [6:0]     cks;
  logic [WCW-1:0] pre_len;
  logic [WCW-1:0] new_good;
  logic [CW-1:0]  new_good_ext;
  logic           too_short;
  logic           rd_hit;

  assign c            = rx_byte_i[6:0] & CH_MASK;
  assign cks          = {1'b0, sum_q & SUM_MASK} + CKS_OFFSET;
  assign pre_len      = wc_q - WCW'(1);
  assign new_good     = (pre_len != '0) ? pre_len - WCW'(1) : '0;
  assign new_good_ext = CW'(new_good);
  assign too_short    = MW'(pre_len) < MW'(min_len_q);
  assign rd_hit       = (CW'(read_index_i) < CW'(good_len_q)) &&
                        (32'(read_index_i) < 32'(BUF_SIZE));

  assign ram_wdata_o = c;
  assign ram_waddr_o = bank_q ? AW'(BUF_SIZE) + AW'(wc_q) : AW'(wc_q);
  assign ram_raddr_o = !bank_q ? AW'(BUF_SIZE) + AW'(read_index_i) : AW'(read_index_i);

  always_comb begin
    min_len_d    = min_len_q;
    start_seen_d = start_seen_q;
    in_group_d   = in_group_q;
    wc_d         = wc_q;
    sum_d        = sum_q;
    last_d       = last_q;
    bank_d       = bank_q;
    good_len_d   = good_len_q;
    res_valid_d  = 1'b0;
    res_d        = '0;
    res_d.status = ST_OK;
    ram_we_o     = 1'b0;
    ram_re_o     = 1'b0;

    if (cfg_we_i) begin
      min_len_d = cfg_wdata_i;
    end

    if (in_valid_i) begin
      if (cmd_i == CMD_READ) begin
        res_valid_d = 1'b1;
        res_d.kind  = KIND_READ;
        res_d.hit   = rd_hit;
        ram_re_o    = rd_hit;
      end else if (in_group_q) begin
        if (c == CH_CR) begin
          res_valid_d = 1'b1;
          in_group_d  = 1'b0;
          if (wc_q == '0) begin
            res_d.status = ST_SHORT;
          end else if (too_short) begin
            wc_d         = '0;
            res_d.status = ST_SHORT;
          end else if (cks != last_q) begin
            wc_d                    = '0;
            res_d.status            = ST_CKS;
            res_d.computed_checksum = cks;
            res_d.received_checksum = last_q;
          end else begin
            good_len_d              = new_good;
            bank_d                  = ~bank_q;
            res_d.group_length      = new_good_ext[6:0];
            res_d.computed_checksum = cks;
            res_d.received_checksum = last_q;
          end
        end else begin
          ram_we_o = 1'b1;
          sum_d    = (sum_q + last_q[5:0]) & SUM_MASK;
          last_d   = c;
          wc_d     = wc_q + WCW'(1);
          if (32'(wc_q) >= 32'(BUF_SIZE - 2)) begin
            in_group_d   = 1'b0;
            res_valid_d  = 1'b1;
            res_d.status = ST_OVF;
          end
        end
      end else if (start_seen_q && (c == CH_LF)) begin
        in_group_d = 1'b1;
        wc_d       = '0;
        sum_d      = '0;
        last_d     = '0;
      end else if (c == CH_STX) begin
        start_seen_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q    <= MIN_LEN_RESET;
      start_seen_q <= 1'b0;
      in_group_q   <= 1'b0;
      wc_q         <= '0;
      sum_q        <= '0;
      last_q       <= '0;
      bank_q       <= 1'b0;
      good_len_q   <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      min_len_q    <= min_len_d;
      start_seen_q <= start_seen_d;
      in_group_q   <= in_group_d;
      wc_q         <= wc_d;
      sum_q        <= sum_d;
      last_q       <= last_d;
      bank_q       <= bank_d;
      good_len_q   <= good_len_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

FILE: rtl/tgfc_back.sv
module tgfc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_valid_i,
  input  tgfc_pkg::front_t res_i,
  input  logic [6:0]       rdata_i,
  output logic             room_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tgfc_pkg::out_t   out_o
);
  import tgfc_pkg::*;

  localparam int unsigned QCW = QPW + 1;

  out_t           ent_q [QDEPTH];
  logic [QPW-1:0] wptr_q, wptr_d;
  logic [QPW-1:0] rptr_q, rptr_d;
  logic [QCW-1:0] count_q, count_d;
  out_t           push_ent;
  logic           push;
  logic           pop;

  always_comb begin
    push_ent.kind              = res_i.kind;
    push_ent.status            = res_i.status;
    push_ent.group_length      = res_i.group_length;
    push_ent.computed_checksum = res_i.computed_checksum;
    push_ent.received_checksum = res_i.received_checksum;
    push_ent.read_data         = (res_i.kind == KIND_READ && res_i.hit) ? rdata_i : '0;
  end

  assign push        = res_valid_i;
  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign out_o       = ent_q[rptr_q];
  assign room_o      = (count_q + QCW'(res_valid_i)) < QCW'(QDEPTH);

  always_comb begin
    wptr_d  = push ? wptr_q + QPW'(1) : wptr_q;
    rptr_d  = pop ? rptr_q + QPW'(1) : rptr_q;
    count_d = count_q + QCW'(push) - QCW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wptr_q] <= push_ent;
    end
  end

endmodule

FILE: rtl/tgfc_checker.sv
module tgfc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_tvalid_i,
  input logic        m_tready_i,
  input logic        m_tuser_i,
  input logic [31:0] m_tdata_i
);
  import tgfc_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i)
    else $error("Result transaction dropped while stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (m_tuser_i == KIND_READ) |-> (m_tdata_i[22:0] == '0))
    else $error("Read reply carries status or checksum bits.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (m_tuser_i == KIND_STATUS) |->
      (m_tdata_i[29:23] == '0) && (m_tdata_i[31:30] == '0))
    else $error("Group status carries read data.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (m_tuser_i == KIND_STATUS) &&
      ((m_tdata_i[1:0] == ST_SHORT) || (m_tdata_i[1:0] == ST_OVF)) |->
      (m_tdata_i[22:2] == '0))
    else $error("Failed group reports length or checksums.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (m_tuser_i == KIND_STATUS) &&
      ((m_tdata_i[1:0] == ST_OK) || (m_tdata_i[1:0] == ST_CKS)) |->
      (m_tdata_i[15:9] >= 7'h20) && (m_tdata_i[15:9] <= 7'h5f))
    else $error("Computed checksum outside the printable range.");

endmodule

bind tic_group_framer_checksum tgfc_checker u_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .m_tvalid_i(m_axis_tvalid_o),
  .m_tready_i(m_axis_tready_i),
  .m_tuser_i (m_axis_tuser_o),
  .m_tdata_i (m_axis_tdata_o)
);
